@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the relay zone controller.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RZC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RZC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rzc_pkg.sv @@
// Package for the relay zone controller: field widths, mode codes, beat types.
// No dependencies; imported by rzc_core and relay_zone_controller.
`timescale 1ns / 1ps

package rzc_pkg;

  localparam int CHAN_W   = 3;
  localparam int FUNC_W   = 3;
  localparam int VAL_W    = 11;
  localparam int BAND_W   = 10;
  localparam int CHAN_SPAN = 1 << CHAN_W;

  localparam int CHANNELS_DEFAULT = 8;

  localparam logic [FUNC_W-1:0] FUNC_DIFF   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_THERMO = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELAY  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SIMPLE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ARRAY  = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0]       channel;
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic [BAND_W-1:0]       band;
    logic                    invert_sense;
    logic                    commanded;
  } item_t;

  typedef struct packed {
    logic relay_drive;
    logic relay_on;
    logic drive_changed;
    logic bad_mode;
  } result_t;

endpackage

@@ rtl/rzc_core.sv @@
// Mode decision for one control step: new relay level from readings and options.
// Depends on rzc_pkg.
`timescale 1ns / 1ps

module rzc_core (
  input  rzc_pkg::item_t   item_i,
  input  logic             old_level_i,
  output rzc_pkg::result_t result_o
);
  import rzc_pkg::*;

  localparam int EXT_W = VAL_W + 2;

  logic signed [EXT_W-1:0] a_x, b_x, band_x, diff, diff_abs, lo, hi;
  logic                    lvl, bad;

  assign a_x      = {{2{item_i.value_a[VAL_W-1]}}, item_i.value_a};
  assign b_x      = {{2{item_i.value_b[VAL_W-1]}}, item_i.value_b};
  assign band_x   = {{(EXT_W-BAND_W){1'b0}}, item_i.band};
  assign diff     = a_x - b_x;
  assign diff_abs = diff[EXT_W-1] ? -diff : diff;
  assign lo       = b_x - band_x;
  assign hi       = b_x + band_x;

  always_comb begin
    lvl = old_level_i;
    bad = 1'b0;
    unique case (item_i.func)
      FUNC_DIFF: begin
        lvl = (diff_abs > band_x) ? item_i.invert_sense : ~item_i.invert_sense;
      end
      FUNC_THERMO: begin
        if (a_x < lo) begin
          lvl = 1'b1;
        end else if (a_x > hi) begin
          lvl = 1'b0;
        end
      end
      FUNC_RELAY:  lvl = item_i.commanded;
      FUNC_SIMPLE: lvl = (a_x < b_x);
      FUNC_ARRAY:  lvl = old_level_i;
      default:     bad = 1'b1;
    endcase
  end

  assign result_o.relay_drive   = lvl;
  assign result_o.relay_on      = lvl;
  assign result_o.drive_changed = lvl ^ old_level_i;
  assign result_o.bad_mode      = bad;

endmodule

@@ rtl/relay_zone_controller.sv @@
// Relay zone controller top level: input register, per-channel relay bits,
// result register. Depends on rzc_pkg, rzc_core and assert_macros.svh.
`timescale 1ns / 1ps

// Each input beat names a relay channel, a mode and readings; one result
// beat follows with the channel's new drive level, on flag, changed flag and
// unknown-mode flag. Without output back-pressure one beat per clock is
// sustained; a beat passes the input register, then the result register.
// The single read-modify-write of the channel's relay bit in the input stage
// sets the rate. Channel numbers wrap modulo CHANNELS; all relays reset off.
`include "assert_macros.svh"

module relay_zone_controller #(
  parameter int CHANNELS = rzc_pkg::CHANNELS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[2:0], value_a[13:3], value_b[24:14], band[34:25],
  // invert_sense[35], commanded[36], zero pad[39:37]
  input  logic [39:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // relay_drive[0], relay_on[1], drive_changed[2], bad_mode[3], zero pad[7:4]
  output logic [7:0]  m_axis_tdata
);
  import rzc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CH_W-1:0] ch_map [CHAN_SPAN];

  for (genvar g = 0; g < CHAN_SPAN; g++) begin : g_map
    assign ch_map[g] = CH_W'(g % CHANNELS);
  end

  item_t           in_item;
  item_t           s1_item_q;
  logic            s1_valid_q;
  logic [CH_W-1:0] s1_idx;
  logic            old_level;
  logic            adv;
  result_t         res;
  result_t         out_res_q;
  logic            out_valid_q;
  logic [CHANNELS-1:0] level_q, level_d;

  assign in_item.channel      = s_axis_tdata[2:0];
  assign in_item.func         = s_axis_tuser;
  assign in_item.value_a      = s_axis_tdata[13:3];
  assign in_item.value_b      = s_axis_tdata[24:14];
  assign in_item.band         = s_axis_tdata[34:25];
  assign in_item.invert_sense = s_axis_tdata[35];
  assign in_item.commanded    = s_axis_tdata[36];

  assign adv           = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~s1_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item_q <= in_item;
    end
  end

  assign s1_idx    = ch_map[s1_item_q.channel];
  assign old_level = level_q[s1_idx];

  rzc_core u_core (
    .item_i      (s1_item_q),
    .old_level_i (old_level),
    .result_o    (res)
  );

  always_comb begin
    level_d = level_q;
    if (adv && s1_valid_q) begin
      level_d[s1_idx] = res.relay_drive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      level_q <= level_d;
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.bad_mode, out_res_q.drive_changed,
                          out_res_q.relay_on, out_res_q.relay_drive};

  `RZC_ASSERT(a_bad_no_change, clk_i, rst_ni, out_valid_q && out_res_q.bad_mode |-> !out_res_q.drive_changed, "unknown mode reported a level change")
  `RZC_ASSERT(a_level_stored, clk_i, rst_ni, adv && s1_valid_q |=> level_q[$past(s1_idx)] == out_res_q.relay_drive, "stored relay level differs from delivered drive")
  `RZC_ASSERT(a_bad_keeps_state, clk_i, rst_ni, adv && s1_valid_q && res.bad_mode |=> level_q == $past(level_q), "unknown mode altered relay state")

endmodule
